>>> src/ole_pkg.sv
`default_nettype none

package ole_pkg;

   // Default sizing of the node store.
   localparam int CAPACITY_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Fixed field widths of the request word.
   localparam int CMD_WIDTH       = 3;
   localparam int FIELD_WIDTH     = 32;
   localparam int REQ_TDATA_WIDTH = 72;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_FRONT  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_BEFORE = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_FIND   = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      STS_DONE    = 2'd0,
      STS_MISSING = 2'd1,
      STS_FULL    = 2'd2,
      STS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEARCH,
      ST_TAIL,
      ST_ALLOC_RD,
      ST_ALLOC_WR,
      ST_LINK_PREV,
      ST_DEL_A,
      ST_DEL_B,
      ST_FINISH
   } state_type;

   typedef struct packed {
      status_type status;
      logic       found;
   } result_type;

endpackage

`default_nettype wire

>>> src/ole_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ole_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/ole_ctrl.sv
`default_nettype none

// Command sequencer: walks the linked list one node-store read per cycle and
// relinks nodes through the write ports of the two memories.
module ole_ctrl #(
   parameter int CAPACITY    = ole_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = ole_pkg::VALUE_WIDTH_DEFAULT,
   localparam int IDXW  = $clog2(CAPACITY),
   localparam int LINKW = $clog2(CAPACITY + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ole_pkg::command_type    req_command,
   input  wire logic [VALUE_WIDTH-1:0]  req_value,
   input  wire logic [VALUE_WIDTH-1:0]  req_anchor,
   output logic                         res_valid,
   input  wire logic                    res_ready,
   output ole_pkg::result_type          res,
   output logic      [LINKW-1:0]        res_count,
   output logic                         res_empty,
   output logic      [IDXW-1:0]         rd_addr,
   input  wire logic [LINKW-1:0]        link_rdata,
   input  wire logic [VALUE_WIDTH-1:0]  value_rdata,
   output logic                         link_we,
   output logic      [IDXW-1:0]         link_waddr,
   output logic      [LINKW-1:0]        link_wdata,
   output logic                         value_we,
   output logic      [IDXW-1:0]         value_waddr,
   output logic      [VALUE_WIDTH-1:0]  value_wdata
);

   localparam logic [LINKW-1:0] NIL      = LINKW'(CAPACITY);
   localparam logic [IDXW-1:0]  INIT_END = IDXW'(CAPACITY - 1);

   ole_pkg::state_type   state_ff, state_in;
   ole_pkg::command_type cmd_ff, cmd_in;
   ole_pkg::status_type  status_ff, status_in;
   logic                 found_ff, found_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [VALUE_WIDTH-1:0] tgt_ff, tgt_in;
   logic [LINKW-1:0]     head_ff, head_in;
   logic [LINKW-1:0]     free_ff, free_in;
   logic [LINKW-1:0]     count_ff, count_in;
   logic [LINKW-1:0]     cur_ff, cur_in;
   logic [LINKW-1:0]     prev_ff, prev_in;
   logic [LINKW-1:0]     nl_ff, nl_in;
   logic [LINKW-1:0]     steps_ff, steps_in;
   logic [IDXW-1:0]      init_ff, init_in;

   logic                 has_free;
   logic                 list_empty;
   logic                 link_ok;
   logic                 prev_ok;
   logic                 match;
   logic [LINKW-1:0]     steps_nx;
   logic                 walk_on;
   logic                 tail_on;
   logic                 init_last;

   assign has_free   = free_ff < NIL;
   assign list_empty = !(head_ff < NIL);
   assign link_ok    = link_rdata < NIL;
   assign prev_ok    = prev_ff < NIL;
   assign match      = value_rdata == tgt_ff;
   assign steps_nx   = steps_ff + LINKW'(1);
   assign walk_on    = link_ok && (steps_nx < NIL);
   assign tail_on    = link_ok && (steps_ff < NIL);
   assign init_last  = init_ff == INIT_END;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ole_pkg::ST_INIT: begin
            if (init_last) begin
               state_in = ole_pkg::ST_IDLE;
            end
         end
         ole_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  ole_pkg::CMD_FRONT, ole_pkg::CMD_APPEND: begin
                     if (!has_free) begin
                        state_in = ole_pkg::ST_FINISH;
                     end else if (req_command == ole_pkg::CMD_FRONT || list_empty) begin
                        state_in = ole_pkg::ST_ALLOC_RD;
                     end else begin
                        state_in = ole_pkg::ST_TAIL;
                     end
                  end
                  ole_pkg::CMD_BEFORE, ole_pkg::CMD_DELETE, ole_pkg::CMD_FIND: begin
                     state_in = list_empty ? ole_pkg::ST_FINISH : ole_pkg::ST_SEARCH;
                  end
                  default: begin
                     state_in = ole_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         ole_pkg::ST_SEARCH: begin
            if (match) begin
               case (cmd_ff)
                  ole_pkg::CMD_BEFORE: begin
                     state_in = has_free ? ole_pkg::ST_ALLOC_RD : ole_pkg::ST_FINISH;
                  end
                  ole_pkg::CMD_DELETE: begin
                     state_in = ole_pkg::ST_DEL_A;
                  end
                  default: begin
                     state_in = ole_pkg::ST_FINISH;
                  end
               endcase
            end else if (!walk_on) begin
               state_in = ole_pkg::ST_FINISH;
            end
         end
         ole_pkg::ST_TAIL: begin
            if (!tail_on) begin
               state_in = ole_pkg::ST_ALLOC_RD;
            end
         end
         ole_pkg::ST_ALLOC_RD: begin
            state_in = ole_pkg::ST_ALLOC_WR;
         end
         ole_pkg::ST_ALLOC_WR: begin
            state_in = prev_ok ? ole_pkg::ST_LINK_PREV : ole_pkg::ST_FINISH;
         end
         ole_pkg::ST_LINK_PREV: begin
            state_in = ole_pkg::ST_FINISH;
         end
         ole_pkg::ST_DEL_A: begin
            state_in = prev_ok ? ole_pkg::ST_DEL_B : ole_pkg::ST_FINISH;
         end
         ole_pkg::ST_DEL_B: begin
            state_in = ole_pkg::ST_FINISH;
         end
         ole_pkg::ST_FINISH: begin
            if (res_ready) begin
               state_in = ole_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ole_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      cmd_in      = cmd_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      val_in      = val_ff;
      tgt_in      = tgt_ff;
      head_in     = head_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      nl_in       = nl_ff;
      steps_in    = steps_ff;
      init_in     = init_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      rd_addr     = cur_ff[IDXW-1:0];
      link_we     = 1'b0;
      link_waddr  = cur_ff[IDXW-1:0];
      link_wdata  = nl_ff;
      value_we    = 1'b0;
      value_waddr = free_ff[IDXW-1:0];
      value_wdata = val_ff;
      case (state_ff)
         ole_pkg::ST_INIT: begin
            // Chain every node into the free list: node i links to node i+1.
            link_we    = 1'b1;
            link_waddr = init_ff;
            link_wdata = LINKW'(init_ff) + LINKW'(1);
            init_in    = init_ff + IDXW'(1);
         end
         ole_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = head_ff[IDXW-1:0];
            if (req_valid) begin
               cmd_in    = req_command;
               val_in    = req_value;
               tgt_in    = (req_command == ole_pkg::CMD_BEFORE) ? req_anchor : req_value;
               status_in = ole_pkg::STS_DONE;
               found_in  = 1'b0;
               cur_in    = head_ff;
               prev_in   = NIL;
               steps_in  = '0;
               case (req_command)
                  ole_pkg::CMD_FRONT, ole_pkg::CMD_APPEND: begin
                     if (!has_free) begin
                        status_in = ole_pkg::STS_FULL;
                     end
                  end
                  ole_pkg::CMD_BEFORE, ole_pkg::CMD_DELETE, ole_pkg::CMD_FIND: begin
                     if (list_empty) begin
                        status_in = ole_pkg::STS_EMPTY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ole_pkg::ST_SEARCH: begin
            if (match) begin
               found_in = 1'b1;
               case (cmd_ff)
                  ole_pkg::CMD_BEFORE: begin
                     if (!has_free) begin
                        status_in = ole_pkg::STS_FULL;
                     end
                     nl_in = cur_ff;
                  end
                  ole_pkg::CMD_DELETE: begin
                     nl_in = link_rdata;
                  end
                  default: begin
                  end
               endcase
            end else if (walk_on) begin
               prev_in  = cur_ff;
               cur_in   = link_rdata;
               steps_in = steps_nx;
               rd_addr  = link_rdata[IDXW-1:0];
            end else begin
               status_in = ole_pkg::STS_MISSING;
            end
         end
         ole_pkg::ST_TAIL: begin
            if (tail_on) begin
               cur_in   = link_rdata;
               steps_in = steps_nx;
               rd_addr  = link_rdata[IDXW-1:0];
            end else begin
               prev_in = cur_ff;
               nl_in   = link_rdata;
            end
         end
         ole_pkg::ST_ALLOC_RD: begin
            rd_addr = free_ff[IDXW-1:0];
         end
         ole_pkg::ST_ALLOC_WR: begin
            // The free head becomes the new node; its link comes back this cycle.
            link_we     = 1'b1;
            link_waddr  = free_ff[IDXW-1:0];
            link_wdata  = prev_ok ? nl_ff : head_ff;
            value_we    = 1'b1;
            value_waddr = free_ff[IDXW-1:0];
            value_wdata = val_ff;
            free_in     = link_rdata;
            count_in    = count_ff + LINKW'(1);
            cur_in      = free_ff;
            if (!prev_ok) begin
               head_in = free_ff;
            end
         end
         ole_pkg::ST_LINK_PREV: begin
            link_we    = 1'b1;
            link_waddr = prev_ff[IDXW-1:0];
            link_wdata = cur_ff;
         end
         ole_pkg::ST_DEL_A: begin
            link_we    = 1'b1;
            link_waddr = cur_ff[IDXW-1:0];
            link_wdata = free_ff;
            free_in    = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - LINKW'(1);
            end
            if (!prev_ok) begin
               head_in = nl_ff;
            end
         end
         ole_pkg::ST_DEL_B: begin
            link_we    = 1'b1;
            link_waddr = prev_ff[IDXW-1:0];
            link_wdata = nl_ff;
         end
         ole_pkg::ST_FINISH: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ole_pkg::ST_INIT;
         init_ff  <= '0;
         head_ff  <= NIL;
         free_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      val_ff    <= val_in;
      tgt_ff    <= tgt_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      nl_ff     <= nl_in;
      steps_ff  <= steps_in;
   end

   assign res       = '{status: status_ff, found: found_ff};
   assign res_count = count_ff;
   assign res_empty = list_empty;

endmodule

`default_nettype wire

>>> src/ordered_list_engine.sv
`default_nettype none

// Ordered list engine: a singly linked list of signed values held in a node
// store of CAPACITY entries, with unused nodes chained into a free list.
// Commands arrive as words on the req_ stream; each command produces exactly
// one result word on the rsp_ stream, in order.
// After reset the engine chains the whole node store into the free list;
// req_tready stays low during this pass and the list is empty.
// Commands are handled one at a time by a sequencer that walks the list one
// node per cycle. A command that needs no walk (an undefined code, a front
// or append on a full store, or a search on an empty list) goes straight to
// its result, and an insert at the front allocates and writes a new node.
// A find walks to the match or the tail; a delete that finds its value then
// returns the node to the free list and, unless it was the head, relinks its
// predecessor. An append walks to the tail and an insert to its anchor; if
// a node is free (and for an insert the anchor is found), the new node is
// written and, unless it becomes the head, linked from its predecessor. The
// next command is taken only after the result enters the output register.
// The result sits in an output register. If the receiver still holds the
// earlier word when the next result is ready, the engine waits with
// req_tready low until that word is taken; no word is dropped or repeated.
module ordered_list_engine #(
   parameter int CAPACITY    = ole_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = ole_pkg::VALUE_WIDTH_DEFAULT,
   localparam int CNTW        = $clog2(CAPACITY + 1),
   localparam int RSP_BITS    = CNTW + 4,
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // command [2:0], value [34:3], anchor [66:35], zero padding above
   input  wire logic [ole_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // status [1:0], found [2], entry_total [CNTW+2:3], is_empty [CNTW+3],
   // zero padding above
   output logic      [RSP_TDATA_W-1:0]                rsp_tdata
);

   localparam int IDXW  = $clog2(CAPACITY);
   localparam int LINKW = $clog2(CAPACITY + 1);
   localparam int FW    = ole_pkg::FIELD_WIDTH;
   localparam int CW    = ole_pkg::CMD_WIDTH;

   // Request fields: values are sign-extended, then kept at VALUE_WIDTH bits.
   ole_pkg::command_type       req_command;
   logic [FW-1:0]              value_raw;
   logic [FW-1:0]              anchor_raw;
   logic [VALUE_WIDTH+FW-1:0]  value_ext;
   logic [VALUE_WIDTH+FW-1:0]  anchor_ext;
   logic [VALUE_WIDTH-1:0]     req_value;
   logic [VALUE_WIDTH-1:0]     req_anchor;

   assign req_command = ole_pkg::command_type'(req_tdata[CW-1:0]);
   assign value_raw   = req_tdata[CW +: FW];
   assign anchor_raw  = req_tdata[CW + FW +: FW];
   assign value_ext   = {{VALUE_WIDTH{value_raw[FW-1]}}, value_raw};
   assign anchor_ext  = {{VALUE_WIDTH{anchor_raw[FW-1]}}, anchor_raw};
   assign req_value   = value_ext[VALUE_WIDTH-1:0];
   assign req_anchor  = anchor_ext[VALUE_WIDTH-1:0];

   // Sequencer and memory connections.
   logic                    res_valid;
   logic                    res_ready;
   ole_pkg::result_type     res;
   logic [CNTW-1:0]         res_count;
   logic                    res_empty;
   logic [IDXW-1:0]         rd_addr;
   logic [LINKW-1:0]        link_rdata;
   logic [VALUE_WIDTH-1:0]  value_rdata;
   logic                    link_we;
   logic [IDXW-1:0]         link_waddr;
   logic [LINKW-1:0]        link_wdata;
   logic                    value_we;
   logic [IDXW-1:0]         value_waddr;
   logic [VALUE_WIDTH-1:0]  value_wdata;

   ole_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (req_command),
      .req_value   (req_value),
      .req_anchor  (req_anchor),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .res_count   (res_count),
      .res_empty   (res_empty),
      .rd_addr     (rd_addr),
      .link_rdata  (link_rdata),
      .value_rdata (value_rdata),
      .link_we     (link_we),
      .link_waddr  (link_waddr),
      .link_wdata  (link_wdata),
      .value_we    (value_we),
      .value_waddr (value_waddr),
      .value_wdata (value_wdata)
   );

   // Link memory: one next-node index per node, NIL being CAPACITY.
   ole_ram #(
      .WIDTH (LINKW),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   // Value memory: read at the same address as the link memory during a walk.
   ole_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (value_waddr),
      .wr_data (value_wdata),
      .rd_addr (rd_addr),
      .rd_data (value_rdata)
   );

   // Output register. It can be reloaded in the same cycle as its word is taken.
   logic                 rsp_valid_ff, rsp_valid_in;
   ole_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [CNTW-1:0]      rsp_count_ff, rsp_count_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_load;

   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = res_valid && res_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res.status;
         rsp_found_in  = res.found;
         rsp_count_in  = res_count;
         rsp_empty_in  = res_empty;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_empty_ff, rsp_count_ff, rsp_found_ff, rsp_status_ff});

`ifndef SYNTHESIS
   // The empty flag and the entry count must tell the same story.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_count_ff == '0)))
      else $error("empty flag disagrees with entry count");

   // The count never exceeds the size of the node store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= CNTW'(CAPACITY)))
      else $error("entry count above capacity");

   // A full report only comes when every node is in the list.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ole_pkg::STS_FULL) |->
         (rsp_count_ff == CNTW'(CAPACITY)))
      else $error("store reported full with free nodes left");

   // An empty report leaves the list empty and nothing found.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ole_pkg::STS_EMPTY) |->
         (rsp_empty_ff && !rsp_found_ff))
      else $error("empty status on a non-empty list");
`endif

endmodule

`default_nettype wire

>>> verif/tb_ordered_list_engine.sv
`timescale 1ns / 1ps

module tb_ordered_list_engine;

   import ole_pkg::*;

   // The engine is built with its default sizing, so the node store holds
   // NODES entries and a link equal to NODES means "no further node".
   localparam int NODES    = CAPACITY_DEFAULT;
   localparam int CNT_BITS = $clog2(NODES + 1);
   localparam int RSP_W    = ((CNT_BITS + 4 + 7) / 8) * 8;
   localparam logic [4:0] NO_LINK = 5'(NODES);

   // Command codes the engine does not define; each must still give one word.
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_C = 3'd7;

   // Each side idles in roughly this many cycles out of a hundred.
   localparam int IDLE_PCT = 37;

   typedef struct {
      logic [CMD_WIDTH-1:0]   command;
      logic [FIELD_WIDTH-1:0] value;
      logic [FIELD_WIDTH-1:0] anchor;
   } list_cmd_t;

   typedef struct {
      status_type          status;
      logic                found;
      logic [CNT_BITS-1:0] entry_total;
      logic                is_empty;
   } outcome_t;

   // The random part runs in phases that lean towards filling the store,
   // draining it, or an even spread of commands.
   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // command [2:0], value [34:3], anchor [66:35], zero padding above
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // status [1:0], found [2], entry_total [7:3], is_empty [8], zero padding above
   logic [RSP_W-1:0]           rsp_tdata;

   ordered_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the list: node values, links, the head of the list, the
   // head of the free chain and the number of nodes in use.
   logic [FIELD_WIDTH-1:0] slot_value [NODES];
   logic [4:0]             slot_link  [NODES];
   logic [4:0]             head_slot;
   logic [4:0]             free_slot;
   int                     entries;

   list_cmd_t pending [$];   // commands not yet offered to the engine
   outcome_t  awaited [$];   // predicted result words, oldest first
   list_cmd_t offered;       // command currently held on the request bus
   logic [FIELD_WIDTH-1:0] value_pool [12];

   int accepted   = 0;
   int received   = 0;
   int mismatches = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;

   // Takes the first free node, stores v in it and links it in after the
   // node 'after', or at the front of the list when 'after' is no node.
   function automatic void attach(logic [FIELD_WIDTH-1:0] v, logic [4:0] after);
      logic [4:0] n;
      n = free_slot;
      free_slot = slot_link[n];
      slot_value[n] = v;
      entries++;
      if (after < NODES) begin
         slot_link[n] = slot_link[after];
         slot_link[after] = n;
      end else begin
         slot_link[n] = head_slot;
         head_slot = n;
      end
   endfunction

   // Applies one command to the shadow list and returns the word that the
   // engine ought to give back for it.
   function automatic outcome_t apply_command(list_cmd_t c);
      outcome_t               o;
      logic [4:0]             prev;
      logic [4:0]             cur;
      logic [4:0]             hit;
      logic [FIELD_WIDTH-1:0] key;
      int                     steps;
      bit                     has_free;
      bit                     empty;
      o.status = STS_DONE;
      o.found  = 1'b0;
      has_free = free_slot < NODES;
      empty    = head_slot >= NODES;
      case (c.command)
         CMD_FRONT, CMD_APPEND: begin
            if (!has_free) begin
               o.status = STS_FULL;
            end else begin
               prev = NO_LINK;
               if (c.command == CMD_APPEND && !empty) begin
                  // Walk to the tail; a stray link or an overlong walk stops it.
                  prev  = head_slot;
                  steps = 0;
                  while (slot_link[prev] < NODES && steps < NODES) begin
                     prev = slot_link[prev];
                     steps++;
                  end
               end
               attach(c.value, prev);
            end
         end
         CMD_BEFORE, CMD_DELETE, CMD_FIND: begin
            if (empty) begin
               o.status = STS_EMPTY;
            end else begin
               key   = (c.command == CMD_BEFORE) ? c.anchor : c.value;
               prev  = NO_LINK;
               hit   = NO_LINK;
               cur   = head_slot;
               steps = 0;
               while (cur < NODES && steps < NODES && hit == NO_LINK) begin
                  if (slot_value[cur] == key) begin
                     hit = cur;
                  end else begin
                     prev = cur;
                     cur  = slot_link[cur];
                     steps++;
                  end
               end
               if (hit == NO_LINK) begin
                  o.status = STS_MISSING;
               end else begin
                  o.found = 1'b1;
                  if (c.command == CMD_BEFORE) begin
                     if (!has_free) begin
                        o.status = STS_FULL;
                     end else begin
                        attach(c.value, prev);
                     end
                  end else if (c.command == CMD_DELETE) begin
                     if (prev < NODES) begin
                        slot_link[prev] = slot_link[hit];
                     end else begin
                        head_slot = slot_link[hit];
                     end
                     slot_link[hit] = free_slot;
                     free_slot = hit;
                     if (entries > 0) begin
                        entries--;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      o.entry_total = CNT_BITS'(entries);
      o.is_empty    = head_slot >= NODES;
      return o;
   endfunction

   task automatic plan_command(logic [CMD_WIDTH-1:0] command,
                               logic [FIELD_WIDTH-1:0] value,
                               logic [FIELD_WIDTH-1:0] anchor);
      list_cmd_t c;
      c.command = command;
      c.value   = value;
      c.anchor  = anchor;
      pending.push_back(c);
   endtask

   // Mostly a value from a small pool, so that searches hit and duplicates
   // turn up; now and then any 32-bit value at all.
   function automatic logic [FIELD_WIDTH-1:0] pick_value();
      if ($urandom_range(0, 99) < 80) begin
         return value_pool[$urandom_range(0, 11)];
      end
      return $urandom;
   endfunction

   // A stretch of the run in which neither side idles at all.
   function automatic bit calm(int n);
      return n >= 600 && n < 800;
   endfunction

   // Request driver. A word stays on the bus until the engine takes it, and
   // the command is predicted at the very edge at which it is accepted.
   always @(posedge clock) begin : request_driver
      bit held;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         held = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            awaited.push_back(apply_command(offered));
            accepted++;
         end
         if (!held) begin
            if (pending.size() > 0
                && (calm(accepted) || $urandom_range(0, 99) >= IDLE_PCT)) begin
               offered = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_TDATA_WIDTH - CMD_WIDTH - 2 * FIELD_WIDTH){1'b0}},
                              offered.anchor, offered.value, offered.command};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Each word taken is checked field by field against the
   // oldest prediction. Once, after a few hundred words, the receiver holds
   // off for a long stretch so that the engine's output register fills and
   // the request side has to stall behind it.
   always @(posedge clock) begin : result_monitor
      outcome_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited.size() == 0) begin
               $error("result word %h arrived with no command outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = awaited.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
                  mismatches++;
               end
               if (rsp_tdata[2] !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_tdata[2]);
                  mismatches++;
               end
               if (rsp_tdata[CNT_BITS+2:3] !== want.entry_total) begin
                  $error("entry_total: expected %0d, actual %0d",
                         want.entry_total, rsp_tdata[CNT_BITS+2:3]);
                  mismatches++;
               end
               if (rsp_tdata[CNT_BITS+3] !== want.is_empty) begin
                  $error("is_empty: expected %0d, actual %0d",
                         want.is_empty, rsp_tdata[CNT_BITS+3]);
                  mismatches++;
               end
            end
            received++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (received == 300 && !stall_done) begin
            stall_done = 1'b1;
            stall_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm(received) || $urandom_range(0, 99) >= IDLE_PCT;
         end
      end
   end

   initial begin
      mix_type mode;
      int      phase_left;
      int      roll;
      logic [CMD_WIDTH-1:0] cmd;

      // Shadow list after reset: every node chained into the free list.
      for (int i = 0; i < NODES; i++) begin
         slot_value[i] = '0;
         slot_link[i]  = 5'(i + 1);
      end
      head_slot = NO_LINK;
      free_slot = '0;
      entries   = 0;

      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      value_pool[4] = 32'h0000_0001;
      for (int i = 5; i < 12; i++) begin
         value_pool[i] = $urandom;
      end

      // Directed opening. Searches on an empty list first, then a small list
      // built at both ends, inserts before the head, in the middle and before
      // a missing anchor, deletes of the head, the tail and a missing
      // value, the undefined commands, and a drain back to empty.
      plan_command(CMD_FIND,    32'h0000_0000, 32'h0000_0000);
      plan_command(CMD_DELETE,  32'h8000_0000, 32'h0000_0000);
      plan_command(CMD_BEFORE,  32'h0000_0001, 32'h7FFF_FFFF);
      plan_command(CMD_APPEND,  32'h7FFF_FFFF, 32'h0000_0000);
      plan_command(CMD_FRONT,   32'h8000_0000, 32'hFFFF_FFFF);
      plan_command(CMD_APPEND,  32'h0000_0000, 32'h8000_0000);
      plan_command(CMD_BEFORE,  32'hFFFF_FFFF, 32'h8000_0000);
      plan_command(CMD_BEFORE,  32'h0000_0001, 32'h0000_0000);
      plan_command(CMD_BEFORE,  32'h1234_5678, 32'h0BAD_CAFE);
      plan_command(CMD_FIND,    32'h7FFF_FFFF, 32'h0000_0000);
      plan_command(CMD_FIND,    32'h0000_002A, 32'hFFFF_FFFF);
      plan_command(CMD_DELETE,  32'hFFFF_FFFF, 32'h0000_0000);
      plan_command(CMD_DELETE,  32'h0000_0000, 32'h0000_0000);
      plan_command(CMD_DELETE,  32'h5555_AAAA, 32'h0000_0000);
      plan_command(CMD_SPARE_A, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      plan_command(CMD_SPARE_B, 32'h8000_0000, 32'h8000_0000);
      plan_command(CMD_SPARE_C, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      plan_command(CMD_APPEND,  32'h0000_0001, 32'h0000_0000);
      plan_command(CMD_DELETE,  32'h0000_0001, 32'h0000_0000);
      plan_command(CMD_DELETE,  32'h8000_0000, 32'h0000_0000);
      plan_command(CMD_DELETE,  32'h7FFF_FFFF, 32'h0000_0000);
      plan_command(CMD_DELETE,  32'h0000_0001, 32'h0000_0000);
      plan_command(CMD_FIND,    32'h0000_0001, 32'h0000_0000);

      // Random phases. Filling phases push the store up to full so that the
      // full cases come up; draining phases run it back down to empty.
      phase_left = 0;
      mode       = MIX_EVEN;
      for (int k = 0; k < 1400; k++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 40);
            roll       = $urandom_range(0, 2);
            mode       = (roll == 0) ? MIX_FILL : (roll == 1) ? MIX_DRAIN : MIX_EVEN;
         end
         phase_left--;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
         end else if (mode == MIX_FILL) begin
            cmd = (roll < 33) ? CMD_FRONT : (roll < 60) ? CMD_APPEND :
                  (roll < 75) ? CMD_BEFORE : (roll < 88) ? CMD_FIND : CMD_DELETE;
         end else if (mode == MIX_DRAIN) begin
            cmd = (roll < 10) ? CMD_FRONT : (roll < 18) ? CMD_APPEND :
                  (roll < 26) ? CMD_BEFORE : (roll < 44) ? CMD_FIND : CMD_DELETE;
         end else begin
            cmd = 3'($urandom_range(CMD_FRONT, CMD_FIND));
         end
         plan_command(cmd, pick_value(), pick_value());
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      while (awaited.size() != 0) begin
         @(posedge clock);
      end
      // Leave room for any stray word the engine might still put out.
      repeat (NODES + 16) @(posedge clock);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, including the long hold-off.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
src/ole_pkg.sv
src/ole_ram.sv
src/ole_ctrl.sv
src/ordered_list_engine.sv
verif/tb_ordered_list_engine.sv
